/* sv/priority_range_flow_table_assert.svh */
// assertion macros for the priority range flow table checker
// expects signals named clk and arst_n in the module that uses them
`ifndef PRIORITY_RANGE_FLOW_TABLE_ASSERT_SVH
`define PRIORITY_RANGE_FLOW_TABLE_ASSERT_SVH

// same-cycle implication, held off during reset
`define PRF_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define PRF_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

/* sv/prf_pkg.sv */
// shared types, sizes and codes for the priority range flow table
// no dependencies
package prf_pkg;

	localparam int MAX_RULES       = 128;
	localparam int LOWEST_PRIORITY = 4;

	localparam int IDX_W      = $clog2(MAX_RULES);
	localparam int TOT_W      = $clog2(MAX_RULES + 1);
	localparam int RI_W       = 7;
	localparam int OUT_IDX_W  = 7;
	localparam int CMP_W      = (RI_W > TOT_W) ? RI_W : TOT_W;
	localparam int ADDR_W     = 16;
	localparam int PRI_W      = 4;
	localparam int BEST_W     = PRI_W + 1;
	localparam int PORT_W     = 4;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PORT_W-1:0] LOCAL_PORT = PORT_W'(3);
	localparam logic [PRI_W-1:0]  RULE0_PRI  = PRI_W'(LOWEST_PRIORITY);
	localparam logic [BEST_W-1:0] BEST_INIT  = BEST_W'(LOWEST_PRIORITY + 1);

	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP_HIGH = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_ADD    = 2'd1,
		FUNC_READ   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		logic              kind;
		logic [PORT_W-1:0] port;
		logic [PRI_W-1:0]  pri;
	} rule_t;

	localparam int RULE_W = $bits(rule_t);

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] dest_ip;
		logic [ADDR_W-1:0] range_low;
		logic [ADDR_W-1:0] range_high;
		logic              action_kind_in;
		logic [PORT_W-1:0] action_port_in;
		logic [PRI_W-1:0]  priority_in;
		logic [RI_W-1:0]   rule_index;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic                 action_kind;
		logic [PORT_W-1:0]    action_port;
		logic [OUT_IDX_W-1:0] matched_index;
		logic [CNT_W-1:0]     packet_count;
		logic [1:0]           status;
	} result_t;

endpackage

/* sv/priority_range_flow_table.sv */
// priority range flow table: lookup, add rule and read count, one item at a time
// lookup scans one rule per cycle, then a hit reads and bumps its counter before the result is
// registered; the next item is taken only once the result has moved to the output register
// add, spare code and out-of-range read go straight to the result; an in-range read first
// fetches its count; a result waits in the output register
// async active-low reset: own range 0..0, one rule (the built-in local rule), counter zero
module priority_range_flow_table
	import prf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [1:0]            func,
	input  logic [ADDR_W-1:0]     dest_ip,
	input  logic [ADDR_W-1:0]     range_low,
	input  logic [ADDR_W-1:0]     range_high,
	input  logic                  action_kind_in,
	input  logic [PORT_W-1:0]     action_port_in,
	input  logic [PRI_W-1:0]      priority_in,
	input  logic [RI_W-1:0]       rule_index,

	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  hit,
	output logic                  action_kind,
	output logic [PORT_W-1:0]     action_port,
	output logic [OUT_IDX_W-1:0]  matched_index,
	output logic [CNT_W-1:0]      packet_count,
	output logic [1:0]            status
);

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_CNT_RD,
		S_CNT_WR,
		S_RD_DATA,
		S_OUT
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic [TOT_W-1:0]     rule_total_q;
	logic [ADDR_W-1:0]    own_low_q;
	logic [ADDR_W-1:0]    own_high_q;
	// counter of the built-in rule lives in a flop, so the count memory needs no clear
	logic [CNT_W-1:0]     cnt0_q;

	// scan pipeline: address issue, then compare in the cycle after on the registered read data
	logic [TOT_W-1:0]     issue_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     tag_s1;
	logic [BEST_W-1:0]    best_q;
	logic                 found_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 m_kind_q;
	logic [PORT_W-1:0]    m_port_q;

	result_t              res_q;
	result_t              out_q;
	logic                 rsp_valid_q;

	// memory ports
	logic                 rule_we;
	logic [IDX_W-1:0]     rule_waddr;
	rule_t                rule_wdata;
	logic [IDX_W-1:0]     rule_raddr;
	logic [RULE_W-1:0]    rule_rdata;
	logic                 cnt_we;
	logic [IDX_W-1:0]     cnt_waddr;
	logic [CNT_W-1:0]     cnt_wdata;
	logic [IDX_W-1:0]     cnt_raddr;
	logic [CNT_W-1:0]     cnt_rdata;

	logic                 out_free;
	logic                 full;
	logic                 is_add;
	logic                 rd_in_range;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     new_addr;
	logic                 issue_more;
	rule_t                builtin_rule;
	rule_t                cur_rule;
	logic                 match;
	logic [CNT_W-1:0]     cnt_old;
	logic [CNT_W-1:0]     cnt_new;
	result_t              exec_res;

	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign full        = (rule_total_q == TOT_W'(MAX_RULES));
	assign is_add      = (state_q == S_EXEC) && (func_t'(req_q.func) == FUNC_ADD) && !full;
	// read index is checked against the rule total; only an in-range read uses the memory data
	assign rd_in_range = CMP_W'(req_q.rule_index) < CMP_W'(rule_total_q);
	assign rd_addr     = IDX_W'(req_q.rule_index);
	assign new_addr    = IDX_W'(rule_total_q);
	assign issue_more  = (issue_q < rule_total_q);

	// rule 0 always follows the current own range registers
	assign builtin_rule = '{
		lo:   own_low_q,
		hi:   own_high_q,
		kind: 1'b0,
		port: LOCAL_PORT,
		pri:  RULE0_PRI
	};
	assign cur_rule = (tag_s1 == '0) ? builtin_rule : rule_t'(rule_rdata);

	// strictly better priority only, so ties keep the earliest rule
	assign match = (req_q.dest_ip >= cur_rule.lo) && (req_q.dest_ip <= cur_rule.hi)
		&& (BEST_W'(cur_rule.pri) < best_q);

	// saturating counter update
	assign cnt_old = (idx_q == '0) ? cnt0_q : cnt_rdata;
	assign cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + CNT_W'(1);

	// first view of the result, taken when the item is decoded
	always_comb begin
		exec_res = '0;
		case (func_t'(req_q.func))
			FUNC_ADD: begin
				if (full) begin
					exec_res.status = ST_FULL;
				end else begin
					exec_res.matched_index = OUT_IDX_W'(rule_total_q);
				end
			end
			FUNC_READ: begin
				exec_res.matched_index = req_q.rule_index;
				if (!rd_in_range) begin
					exec_res.status = ST_ABSENT;
				end
			end
			default: ;
		endcase
	end

	// rule memory: written by add, read by the scan
	assign rule_we    = is_add;
	assign rule_waddr = new_addr;
	assign rule_wdata = '{
		lo:   req_q.range_low,
		hi:   req_q.range_high,
		kind: req_q.action_kind_in,
		port: req_q.action_port_in,
		pri:  req_q.priority_in
	};
	assign rule_raddr = IDX_W'(issue_q);

	// count memory: zeroed by add, bumped after a hit, read by read and by lookup
	assign cnt_we    = is_add || ((state_q == S_CNT_WR) && (idx_q != '0));
	assign cnt_waddr = is_add ? new_addr : idx_q;
	assign cnt_wdata = is_add ? '0 : cnt_new;
	assign cnt_raddr = (state_q == S_EXEC) ? rd_addr : idx_q;

	prf_ram #(
		.WIDTH (RULE_W),
		.DEPTH (MAX_RULES)
	) u_rule_ram (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (rule_wdata),
		.raddr (rule_raddr),
		.rdata (rule_rdata)
	);

	prf_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_RULES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// sequencer, configuration registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rule_total_q <= TOT_W'(1);
			own_low_q    <= '0;
			own_high_q   <= '0;
			cnt0_q       <= '0;
			vld_s1       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OWN_IP_LOW:  own_low_q  <= cfg_data;
					REG_OWN_IP_HIGH: own_high_q <= cfg_data;
					default: ;
				endcase
			end

			// output valid: set when a result moves out, cleared once taken
			if ((state_q == S_OUT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= '{
							func:           func,
							dest_ip:        dest_ip,
							range_low:      range_low,
							range_high:     range_high,
							action_kind_in: action_kind_in,
							action_port_in: action_port_in,
							priority_in:    priority_in,
							rule_index:     rule_index
						};
						state_q <= S_EXEC;
					end
				end

				S_EXEC: begin
					res_q <= exec_res;
					case (func_t'(req_q.func))
						FUNC_LOOKUP: begin
							issue_q  <= '0;
							vld_s1   <= 1'b0;
							best_q   <= BEST_INIT;
							found_q  <= 1'b0;
							idx_q    <= '0;
							m_kind_q <= 1'b0;
							m_port_q <= '0;
							state_q  <= S_SCAN;
						end
						FUNC_ADD: begin
							if (!full) begin
								rule_total_q <= rule_total_q + TOT_W'(1);
							end
							state_q <= S_OUT;
						end
						FUNC_READ: begin
							if (rd_in_range) begin
								state_q <= S_RD_DATA;
							end else begin
								state_q <= S_OUT;
							end
						end
						default: begin
							// spare code: all-zero result, no state change
							state_q <= S_OUT;
						end
					endcase
				end

				S_SCAN: begin
					vld_s1 <= issue_more;
					tag_s1 <= IDX_W'(issue_q);
					if (issue_more) begin
						issue_q <= issue_q + TOT_W'(1);
					end
					if (vld_s1 && match) begin
						best_q   <= BEST_W'(cur_rule.pri);
						found_q  <= 1'b1;
						idx_q    <= tag_s1;
						m_kind_q <= cur_rule.kind;
						m_port_q <= cur_rule.port;
					end
					// pipeline drained: every rule has been compared
					if (!issue_more && !vld_s1) begin
						state_q <= found_q ? S_CNT_RD : S_OUT;
					end
				end

				S_CNT_RD: begin
					state_q <= S_CNT_WR;
				end

				S_CNT_WR: begin
					if (idx_q == '0) begin
						cnt0_q <= cnt_new;
					end
					res_q <= '{
						hit:           1'b1,
						action_kind:   m_kind_q,
						action_port:   m_port_q,
						matched_index: OUT_IDX_W'(idx_q),
						packet_count:  cnt_new,
						status:        ST_OK
					};
					state_q <= S_OUT;
				end

				S_RD_DATA: begin
					res_q.packet_count <= (req_q.rule_index == '0) ? cnt0_q : cnt_rdata;
					state_q            <= S_OUT;
				end

				S_OUT: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign hit           = out_q.hit;
	assign action_kind   = out_q.action_kind;
	assign action_port   = out_q.action_port;
	assign matched_index = out_q.matched_index;
	assign packet_count  = out_q.packet_count;
	assign status        = out_q.status;

endmodule

/* sv/prf_ram.sv */
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module prf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/prf_checker.sv */
// port-level checks for the priority range flow table, bound to the top level
// depends on prf_pkg and priority_range_flow_table_assert.svh
`include "priority_range_flow_table_assert.svh"

module prf_checker
	import prf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input logic                 hit,
	input logic                 action_kind,
	input logic [PORT_W-1:0]    action_port,
	input logic [OUT_IDX_W-1:0] matched_index,
	input logic [CNT_W-1:0]     packet_count,
	input logic [1:0]           status
);

	// items taken in but not yet answered
	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_acc && !req_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`PRF_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(packet_count) && $stable(matched_index) && $stable(status),
		"result item dropped or changed while stalled")
	`PRF_ASSERT_IMP(a_rsp_owed, rsp_valid, pend_q != 2'd0,
		"result item with no item outstanding")
	`PRF_ASSERT_IMP(a_hit_ok, rsp_valid && hit, status == ST_OK,
		"hit reported with an error status")
	`PRF_ASSERT_IMP(a_miss_quiet, rsp_valid && !hit,
		(action_kind == 1'b0) && (action_port == '0),
		"action fields set without a hit")

endmodule

bind priority_range_flow_table prf_checker u_prf_checker (.*);

/* bench/testbench.sv */
// self-checking bench for the priority range flow table: directed table, then random phases
// keeps its own model of the rule table and hit counters and compares every result item
// depends on prf_pkg and priority_range_flow_table
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import prf_pkg::*;

	// spare function code, answered with an all-zero item
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam int NPHASE     = 6;
	localparam int PHASE_LEN  = 100;
	localparam int HOLD_LEN   = 400;
	localparam int SETTLE     = 20;
	localparam int TAIL       = 200;
	localparam int CYCLE_CAP  = 400000;
	localparam int SHOW_FAULT = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	logic [1:0]            func;
	logic [ADDR_W-1:0]     dest_ip;
	logic [ADDR_W-1:0]     range_low;
	logic [ADDR_W-1:0]     range_high;
	logic                  action_kind_in;
	logic [PORT_W-1:0]     action_port_in;
	logic [PRI_W-1:0]      priority_in;
	logic [RI_W-1:0]       rule_index;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic                  hit;
	logic                  action_kind;
	logic [PORT_W-1:0]     action_port;
	logic [OUT_IDX_W-1:0]  matched_index;
	logic [CNT_W-1:0]      packet_count;
	logic [1:0]            status;

	priority_range_flow_table u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.func           (func),
		.dest_ip        (dest_ip),
		.range_low      (range_low),
		.range_high     (range_high),
		.action_kind_in (action_kind_in),
		.action_port_in (action_port_in),
		.priority_in    (priority_in),
		.rule_index     (rule_index),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.hit            (hit),
		.action_kind    (action_kind),
		.action_port    (action_port),
		.matched_index  (matched_index),
		.packet_count   (packet_count),
		.status         (status)
	);

	// one row of the directed table: the item, and a hand-written answer where it is obvious
	typedef struct {
		req_t    req;
		bit      known;
		result_t want;
	} dir_row_t;

	// shadow copy of the table state
	rule_t             rules_m [MAX_RULES];
	logic [CNT_W-1:0]  counts_m [MAX_RULES];
	int unsigned       total_m;
	logic [ADDR_W-1:0] own_lo_m;
	logic [ADDR_W-1:0] own_hi_m;

	result_t     pending_q [$];
	dir_row_t    dir_tab [$];

	int          fault_count;
	int          rx_count;
	int          rx_wait;
	bit          no_gaps;
	int unsigned cyc;
	int          n_items, n_lookup, n_hits, n_add, n_full, n_read, n_settings;

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, ends the run if the block hangs
	initial begin
		cyc = 0;
		while (cyc < CYCLE_CAP) begin
			@(posedge clk);
			cyc++;
		end
		$display("timeout after %0d cycles, %0d results still awaited", cyc, pending_q.size());
		$display("Test completed with failures");
		$finish;
	end

	// rule 0 is rebuilt from the own-range registers every time it is looked at
	function automatic rule_t rule_at(int unsigned i);
		rule_t t;
		if (i == 0) begin
			t.lo   = own_lo_m;
			t.hi   = own_hi_m;
			t.kind = 1'b0;
			t.port = LOCAL_PORT;
			t.pri  = RULE0_PRI;
		end else begin
			t = rules_m[i];
		end
		return t;
	endfunction

	// works out the answer to one item and moves the shadow state on
	function automatic result_t flow_predict(req_t r);
		result_t         o;
		rule_t           t;
		logic [BEST_W-1:0] best;
		bit              found;
		int unsigned     idx;
		o = '0;
		case (r.func)
			FUNC_LOOKUP: begin
				best  = BEST_INIT;
				found = 1'b0;
				idx   = 0;
				// strict compare, so the earliest rule keeps a tie
				for (int unsigned i = 0; i < total_m; i++) begin
					t = rule_at(i);
					if (r.dest_ip >= t.lo && r.dest_ip <= t.hi && {1'b0, t.pri} < best) begin
						best  = {1'b0, t.pri};
						found = 1'b1;
						idx   = i;
					end
				end
				if (found) begin
					t = rule_at(idx);
					// counter sticks at all ones
					if (counts_m[idx] != '1)
						counts_m[idx]++;
					o.hit           = 1'b1;
					o.action_kind   = t.kind;
					o.action_port   = t.port;
					o.matched_index = OUT_IDX_W'(idx);
					o.packet_count  = counts_m[idx];
				end
			end
			FUNC_ADD: begin
				if (total_m >= MAX_RULES) begin
					o.status = ST_FULL;
				end else begin
					rules_m[total_m] = '{lo: r.range_low, hi: r.range_high,
						kind: r.action_kind_in, port: r.action_port_in, pri: r.priority_in};
					counts_m[total_m] = '0;
					o.matched_index   = OUT_IDX_W'(total_m);
					total_m++;
				end
			end
			FUNC_READ: begin
				o.matched_index = r.rule_index;
				if (r.rule_index < total_m)
					o.packet_count = counts_m[r.rule_index];
				else
					o.status = ST_ABSENT;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic req_t mk_req(logic [1:0] f, logic [15:0] d, logic [15:0] lo,
			logic [15:0] hi, logic k, logic [3:0] p, logic [3:0] pr, logic [6:0] ri);
		req_t r;
		r.func           = f;
		r.dest_ip        = d;
		r.range_low      = lo;
		r.range_high     = hi;
		r.action_kind_in = k;
		r.action_port_in = p;
		r.priority_in    = pr;
		r.rule_index     = ri;
		return r;
	endfunction

	function automatic result_t mk_res(logic h, logic k, logic [3:0] p, logic [6:0] mi,
			logic [31:0] cnt, logic [1:0] st);
		result_t o;
		o.hit           = h;
		o.action_kind   = k;
		o.action_port   = p;
		o.matched_index = mi;
		o.packet_count  = cnt;
		o.status        = st;
		return o;
	endfunction

	// random item, mostly aimed at live rules so that lookups really hit
	function automatic req_t pick_item(int add_pct);
		req_t        r;
		rule_t       t;
		int unsigned roll, k, a, b, span;
		r.func           = 2'($urandom);
		r.dest_ip        = 16'($urandom);
		r.range_low      = 16'($urandom);
		r.range_high     = 16'($urandom);
		r.action_kind_in = 1'($urandom);
		r.action_port_in = 4'($urandom);
		r.priority_in    = 4'($urandom);
		r.rule_index     = 7'($urandom);
		roll = $urandom_range(99);
		k    = $urandom_range(9);
		if (roll < 5) begin
			r.func = FUNC_SPARE;
		end else if (roll < 5 + add_pct) begin
			r.func = FUNC_ADD;
			a = $urandom_range(16'hFFFF);
			b = $urandom_range(16'hFFFF);
			if (k < 5) begin
				// narrow range, clipped at the top of the address space
				span = $urandom_range(255);
				r.range_low  = 16'(a);
				r.range_high = (a + span > 16'hFFFF) ? 16'hFFFF : 16'(a + span);
			end else if (k < 8) begin
				r.range_low  = 16'((a < b) ? a : b);
				r.range_high = 16'((a < b) ? b : a);
			end else if (k < 9) begin
				// inverted range
				r.range_low  = 16'((a < b) ? b : a);
				r.range_high = 16'((a < b) ? a : b);
			end else begin
				r.range_low  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				r.range_high = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			end
			// mostly priorities that can win, some too weak to ever match
			if ($urandom_range(9) < 8)
				r.priority_in = PRI_W'($urandom_range(LOWEST_PRIORITY));
			else
				r.priority_in = PRI_W'($urandom_range(15, LOWEST_PRIORITY + 1));
		end else if (roll < 25 + add_pct) begin
			r.func = FUNC_READ;
			if (k < 7)
				r.rule_index = RI_W'($urandom_range(total_m - 1));
		end else begin
			r.func = FUNC_LOOKUP;
			if (k < 6) begin
				t = rule_at($urandom_range(total_m - 1));
				if (k == 0)
					r.dest_ip = t.lo;
				else if (k == 1)
					r.dest_ip = t.hi;
				else if (t.lo <= t.hi)
					r.dest_ip = 16'($urandom_range(t.hi, t.lo));
			end else if (k == 9) begin
				r.dest_ip = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			end
		end
		return r;
	endfunction

	function automatic void report_fault(string msg);
		fault_count++;
		if (fault_count <= SHOW_FAULT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// offers one item after a random gap and logs its answer once it is taken
	task automatic send_item(input req_t r, input bit known, input result_t want);
		int      gap;
		result_t model_out;
		gap = no_gaps ? 0 : $urandom_range(5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid      <= 1'b1;
		func           <= r.func;
		dest_ip        <= r.dest_ip;
		range_low      <= r.range_low;
		range_high     <= r.range_high;
		action_kind_in <= r.action_kind_in;
		action_port_in <= r.action_port_in;
		priority_in    <= r.priority_in;
		rule_index     <= r.rule_index;
		do
			@(posedge clk);
		while (req_stall);
		model_out = flow_predict(r);
		pending_q.push_back(known ? want : model_out);
		n_items++;
		case (r.func)
			FUNC_LOOKUP: begin
				n_lookup++;
				n_hits += model_out.hit;
			end
			FUNC_ADD: begin
				n_add++;
				n_full += (model_out.status == ST_FULL);
			end
			FUNC_READ: n_read++;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// sender pauses until every answer is back, then lets the block settle
	task automatic wait_idle(input int settle);
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// writes both own-range registers back to back, only ever called when idle
	task automatic set_own_range(input logic [15:0] lo, input logic [15:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_OWN_IP_LOW;
		cfg_data  <= lo;
		@(negedge clk);
		own_lo_m  = lo;
		cfg_index <= REG_OWN_IP_HIGH;
		cfg_data  <= hi;
		@(negedge clk);
		own_hi_m  = hi;
		cfg_we    <= 1'b0;
		@(negedge clk);
		n_settings++;
	endtask

	// receiver side: answers are checked in order against the oldest logged one
	always @(posedge clk) begin : check_answers
		result_t got;
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got.hit           = hit;
			got.action_kind   = action_kind;
			got.action_port   = action_port;
			got.matched_index = matched_index;
			got.packet_count  = packet_count;
			got.status        = status;
			rx_count++;
			// two long hold-offs so the block backs up and stalls its input
			if (rx_count == 60 || rx_count == 420)
				rx_wait = HOLD_LEN;
			else
				rx_wait = no_gaps ? 0 : $urandom_range(5);
			if (pending_q.size() == 0) begin
				report_fault($sformatf("unexpected item: hit %0d kind %0d port %0d idx %0d cnt %0d st %0d",
					got.hit, got.action_kind, got.action_port, got.matched_index,
					got.packet_count, got.status));
			end else begin
				want = pending_q.pop_front();
				if (got.hit !== want.hit || got.action_kind !== want.action_kind ||
						got.action_port !== want.action_port ||
						got.matched_index !== want.matched_index ||
						got.packet_count !== want.packet_count || got.status !== want.status)
					report_fault($sformatf({"item %0d mismatch: hit %0d/%0d kind %0d/%0d port %0d/%0d ",
						"idx %0d/%0d cnt %0d/%0d st %0d/%0d (expected/actual)"}, rx_count,
						want.hit, got.hit, want.action_kind, got.action_kind,
						want.action_port, got.action_port, want.matched_index, got.matched_index,
						want.packet_count, got.packet_count, want.status, got.status));
			end
		end
	end

	// stall counter for the receiver, loaded on every accepted item
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_wait > 0) begin
				rsp_stall <= 1'b1;
				rx_wait--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		logic [15:0] lo, hi, a, b;
		// every input known from time zero
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		req_valid      = 1'b0;
		func           = '0;
		dest_ip        = '0;
		range_low      = '0;
		range_high     = '0;
		action_kind_in = 1'b0;
		action_port_in = '0;
		priority_in    = '0;
		rule_index     = '0;
		// shadow state as after reset
		total_m  = 1;
		own_lo_m = '0;
		own_hi_m = '0;
		foreach (counts_m[i])
			counts_m[i] = '0;
		fault_count = 0;
		rx_count    = 0;
		rx_wait     = 0;
		no_gaps     = 1'b0;
		n_items = 0; n_lookup = 0; n_hits = 0; n_add = 0; n_full = 0; n_read = 0;
		n_settings = 0;

		// directed part, run on the reset own range of address 0 only
		// reset state: only rule 0, counters zero
		dir_tab.push_back('{mk_req(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 0, ST_OK)});
		dir_tab.push_back('{mk_req(FUNC_READ, 0, 0, 0, 0, 0, 0, 1), 1'b1,
			mk_res(0, 0, 0, 1, 0, ST_ABSENT)});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h0000, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1, 0, LOCAL_PORT, 0, 1, ST_OK)});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h0001, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 0, ST_OK)});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 0, ST_OK)});
		// spare code with every field at its top value
		dir_tab.push_back('{mk_req(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 15, 15, 127),
			1'b1, mk_res(0, 0, 0, 0, 0, ST_OK)});
		dir_tab.push_back('{mk_req(FUNC_ADD, 0, 16'h1800, 16'h18FF, 1, 7, 2, 0), 1'b1,
			mk_res(0, 0, 0, 1, 0, ST_OK)});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h1800, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// full-width rule that is too weak to ever match
		dir_tab.push_back('{mk_req(FUNC_ADD, 0, 16'h0000, 16'hFFFF, 0, 15, 15, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h1234, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// same range and priority as rule 1, earlier rule must keep the tie
		dir_tab.push_back('{mk_req(FUNC_ADD, 0, 16'h1800, 16'h18FF, 0, 5, 2, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h18FF, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// inverted range matches nothing
		dir_tab.push_back('{mk_req(FUNC_ADD, 0, 16'h5000, 16'h4FFF, 0, 1, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h5000, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// single address at top priority beats the overlapping rules
		dir_tab.push_back('{mk_req(FUNC_ADD, 0, 16'h1850, 16'h1850, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h1850, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_ADD, 0, 16'hFFFF, 16'hFFFF, 1, 9, 4, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// ties with the built-in rule at the lowest priority
		dir_tab.push_back('{mk_req(FUNC_ADD, 0, 16'h0000, 16'h0000, 0, 12, 4, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h0000, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_READ, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_READ, 0, 0, 0, 0, 0, 0, 127), 1'b1,
			mk_res(0, 0, 0, 127, 0, ST_ABSENT)});
		dir_tab.push_back('{mk_req(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_ADD, 0, 16'h0000, 16'hFFFF, 0, 1, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_req(FUNC_LOOKUP, 16'h8000, 0, 0, 0, 0, 0, 0), 1'b0, '0});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].req, dir_tab[i].known, dir_tab[i].want);

		// random phases, each on its own own-range setting
		for (int p = 0; p < NPHASE; p++) begin
			wait_idle(SETTLE);
			case (p)
				0: begin lo = 16'h0000; hi = 16'hFFFF; end
				1: begin lo = 16'hFFFF; hi = 16'hFFFF; end
				2: begin lo = 16'h9000; hi = 16'h8000; end
				3: begin lo = 16'h0000; hi = 16'h0000; end
				default: begin
					a  = 16'($urandom);
					b  = 16'($urandom);
					lo = (a < b) ? a : b;
					hi = (a < b) ? b : a;
				end
			endcase
			set_own_range(lo, hi);
			for (int n = 0; n < PHASE_LEN; n++) begin
				// stretches with no idling on either side
				if (n % 25 == 0)
					no_gaps = ($urandom_range(3) == 0);
				// last phase leans on adds to keep hitting the full table
				send_item(pick_item((p == NPHASE - 1) ? 40 : 25), 1'b0, '0);
			end
		end

		wait_idle(TAIL);
		$display("%0d items, %0d results checked: %0d lookups (%0d hits), %0d adds (%0d refused, table full), %0d reads",
			n_items, rx_count, n_lookup, n_hits, n_add, n_full, n_read);
		$display("%0d own-range settings, final rule total %0d, %0d cycles, %0d faults",
			n_settings, total_m, cyc, fault_count);
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
